FILE: hdl/mbss_pkg.sv
// ----------------------------------------------------------------------------
// mbss_pkg
// Shared types and constants for the masked byte signature scan.
// ----------------------------------------------------------------------------
package mbss_pkg;

  localparam int PATTERN_MAX  = 16;
  localparam int OFFSET_BITS  = 32;
  localparam int WINDOW_DEPTH = PATTERN_MAX - 1;
  localparam int LEN_BITS     = 5;
  localparam int COUNT_BITS   = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [7:0] NIB_LO_MASK = 8'h0F;
  localparam logic [7:0] NIB_HI_MASK = 8'hF0;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PATTERN_LOW      = 3'd0,
    CFG_PATTERN_HIGH     = 3'd1,
    CFG_NIBBLE_CARE      = 3'd2,
    CFG_PATTERN_LENGTH   = 3'd3,
    CFG_OCCURRENCE_INDEX = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [63:0]           pattern_low;
    logic [63:0]           pattern_high;
    logic [31:0]           nibble_care;
    logic [LEN_BITS-1:0]   pattern_length;
    logic [COUNT_BITS-1:0] occurrence_index;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] match_offset;
  } out_item_t;

endpackage

FILE: hdl/masked_byte_signature_scan.sv
// ----------------------------------------------------------------------------
// masked_byte_signature_scan
// Byte-stream search for a 1..16 byte signature with per-nibble wildcards.
// ----------------------------------------------------------------------------
// One byte is taken per clock unless the input stalls. A byte passes through
// the input register, then a combinational parallel compare of the full
// 16-byte window updates the scan state and loads the result register. At
// most one result per region: found=1 with the start offset of match number
// occurrence_index, or found=0 on the last byte if that match never
// completed. The input stalls only while the result register holds an item
// that the output side has not taken. Write configuration only while no
// bytes are in flight.
module masked_byte_signature_scan (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  mbss_pkg::in_item_t                      in_item,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output mbss_pkg::out_item_t                     out_item,
  input  logic                                    cfg_write,
  input  logic [mbss_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [mbss_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import mbss_pkg::*;

  cfg_t     cfg;
  logic     s1_valid;
  in_item_t s1_item;
  logic     take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low      <= '0;
      cfg.pattern_high     <= '0;
      cfg.nibble_care      <= '1;
      cfg.pattern_length   <= LEN_BITS'(1);
      cfg.occurrence_index <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:      cfg.pattern_low      <= cfg_data;
        CFG_PATTERN_HIGH:     cfg.pattern_high     <= cfg_data;
        CFG_NIBBLE_CARE:      cfg.nibble_care      <= cfg_data[31:0];
        CFG_PATTERN_LENGTH:   cfg.pattern_length   <= cfg_data[LEN_BITS-1:0];
        CFG_OCCURRENCE_INDEX: cfg.occurrence_index <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = s1_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_item;
    end
  end

  mbss_scan_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (s1_valid),
    .item       (s1_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

FILE: hdl/mbss_window_compare.sv
// ----------------------------------------------------------------------------
// mbss_window_compare
// Parallel nibble-masked compare of the signature against the byte window.
// ----------------------------------------------------------------------------
module mbss_window_compare (
  input  mbss_pkg::cfg_t                                   cfg,
  input  logic [mbss_pkg::WINDOW_DEPTH-1:0][7:0]           byte_window,
  input  logic [7:0]                                       cur_byte,
  input  logic [mbss_pkg::LEN_BITS-1:0]                    len,
  output logic                                             hit
);
  import mbss_pkg::*;

  logic [PATTERN_MAX-1:0][7:0] seq;   // seq[0] newest byte
  logic [PATTERN_MAX-1:0][7:0] sig;
  logic [PATTERN_MAX-1:0]      mism;

  assign seq = {byte_window, cur_byte};
  assign sig = {cfg.pattern_high, cfg.pattern_low};

  always_comb begin
    logic [LEN_BITS-1:0] age;
    logic [7:0]          diff;
    age  = '0;
    diff = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      // signature byte k lines up with the byte len-1-k positions back
      age     = len - LEN_BITS'(k) - LEN_BITS'(1);
      diff    = seq[age[LEN_BITS-2:0]] ^ sig[k];
      mism[k] = (LEN_BITS'(k) < len) &&
                ((cfg.nibble_care[2*k]   && ((diff & NIB_LO_MASK) != 8'h00)) ||
                 (cfg.nibble_care[2*k+1] && ((diff & NIB_HI_MASK) != 8'h00)));
    end
  end

  assign hit = (mism == '0);

endmodule

FILE: hdl/mbss_scan_core.sv
// ----------------------------------------------------------------------------
// mbss_scan_core
// Scan state (window, position, counts) and the result register.
// ----------------------------------------------------------------------------
module mbss_scan_core (
  input  logic                clk,
  input  logic                rst,
  input  mbss_pkg::cfg_t      cfg,
  input  logic                item_valid,
  input  mbss_pkg::in_item_t  item,
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output mbss_pkg::out_item_t out_item
);
  import mbss_pkg::*;

  logic [WINDOW_DEPTH-1:0][7:0] byte_window;
  logic [OFFSET_BITS-1:0]       stream_position;
  logic [COUNT_BITS-1:0]        match_count;
  logic                         reported;
  logic [LEN_BITS-1:0]          fill;

  logic [LEN_BITS-1:0] len;
  logic [LEN_BITS-1:0] fill_next;
  logic                hit;
  logic                hit_ok;
  logic                report;
  logic                emit;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = LEN_BITS'(1);
    end else if (cfg.pattern_length > LEN_BITS'(PATTERN_MAX)) begin
      len = LEN_BITS'(PATTERN_MAX);
    end else begin
      len = cfg.pattern_length;
    end
  end

  mbss_window_compare u_compare (
    .cfg         (cfg),
    .byte_window (byte_window),
    .cur_byte    (item.data_byte),
    .len         (len),
    .hit         (hit)
  );

  assign take      = item_valid && (!out_valid || !out_stall);
  assign fill_next = (fill < LEN_BITS'(PATTERN_MAX)) ? fill + LEN_BITS'(1) : fill;
  assign hit_ok    = !reported && (fill_next >= len) && hit;
  assign report    = hit_ok && (match_count == cfg.occurrence_index);
  // not-found goes out only at region end and only if nothing was reported
  assign emit      = report || (item.last_byte && !reported);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window     <= '0;
      stream_position <= '0;
      match_count     <= '0;
      reported        <= 1'b0;
      fill            <= '0;
    end else if (take) begin
      if (item.last_byte) begin
        byte_window     <= '0;
        stream_position <= '0;
        match_count     <= '0;
        reported        <= 1'b0;
        fill            <= '0;
      end else begin
        byte_window     <= {byte_window[WINDOW_DEPTH-2:0], item.data_byte};
        stream_position <= stream_position + OFFSET_BITS'(1);
        fill            <= fill_next;
        if (report) begin
          reported <= 1'b1;
        end else if (hit_ok) begin
          match_count <= match_count + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_item.found        <= report;
      out_item.match_offset <= report ?
                               stream_position - OFFSET_BITS'(len - LEN_BITS'(1)) : '0;
    end
  end

endmodule

FILE: test/tb_masked_byte_signature_scan.sv
// ----------------------------------------------------------------------------
// tb_masked_byte_signature_scan
// Self-checking testbench for the masked byte signature scan.
// ----------------------------------------------------------------------------
// Bytes are pushed through a bursty driver and results are taken by a
// receiver that stalls on a changing pattern. A behavioral scan model
// predicts the report for every accepted byte, and the monitor checks each
// result against the oldest prediction. Directed regions cover the field
// extremes and corner cases, followed by random regions that embed the
// signature with random wildcard content.
// ----------------------------------------------------------------------------
module tb_masked_byte_signature_scan;
  timeunit 1ns;
  timeprecision 1ps;

  import mbss_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int STUCK_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  masked_byte_signature_scan uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scan model state and its copy of the registers
  cfg_t scan_cfg = '{pattern_low: '0, pattern_high: '0, nibble_care: '1,
                     pattern_length: 5'd1, occurrence_index: '0};
  logic [7:0] recent [WINDOW_DEPTH];
  logic [OFFSET_BITS-1:0] position = '0;
  logic [COUNT_BITS-1:0] hits_seen = '0;
  bit already_reported = 1'b0;
  int unsigned seen = 0;

  in_item_t byte_q [$];
  out_item_t awaited_reports [$];
  int errors = 0;
  bit byte_taken = 1'b0;
  bit steady_send = 1'b0;
  bit hold_req = 1'b0;
  int unsigned stuck_cycles = 0;

  initial begin
    for (int i = 0; i < WINDOW_DEPTH; i++) recent[i] = '0;
  end

  function automatic int unsigned active_length();
    int unsigned len;
    len = scan_cfg.pattern_length;
    if (len < 1) len = 1;
    if (len > PATTERN_MAX) len = PATTERN_MAX;
    return len;
  endfunction

  // Advance the scan by one byte; hit tells whether a report is due.
  function automatic void scan_byte(input in_item_t it, output bit hit,
                                    output out_item_t rep);
    int unsigned len;
    int unsigned k;
    bit ok;
    logic [7:0] b;
    logic [7:0] diff;
    logic [127:0] sig;
    hit = 1'b0;
    rep = '0;
    len = active_length();
    sig = {scan_cfg.pattern_high, scan_cfg.pattern_low};
    if (seen < PATTERN_MAX) seen++;
    if (!already_reported && seen >= len) begin
      ok = 1'b1;
      for (k = 0; k < len; k++) begin
        b = (k + 1 == len) ? it.data_byte : recent[len - 2 - k];
        diff = b ^ sig[8*k +: 8];
        if (scan_cfg.nibble_care[2*k] && (diff & NIB_LO_MASK) != 0) ok = 1'b0;
        if (scan_cfg.nibble_care[2*k+1] && (diff & NIB_HI_MASK) != 0) ok = 1'b0;
      end
      if (ok) begin
        if (hits_seen == scan_cfg.occurrence_index) begin
          already_reported = 1'b1;
          hit = 1'b1;
          rep.found = 1'b1;
          rep.match_offset = position - OFFSET_BITS'(len - 1);
        end else begin
          hits_seen++;
        end
      end
    end
    if (it.last_byte) begin
      if (!hit && !already_reported) begin
        hit = 1'b1;
        rep = '0;
      end
      for (k = 0; k < WINDOW_DEPTH; k++) recent[k] = '0;
      position = '0;
      hits_seen = '0;
      already_reported = 1'b0;
      seen = 0;
    end else begin
      for (k = WINDOW_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = it.data_byte;
      position++;
    end
  endfunction

  // Byte driver: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else if (!in_valid || byte_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_item <= byte_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          if (!steady_send)
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                   : $urandom_range(0, 2);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: rotating stall pattern that is redrawn at random, or a held stall on request
  logic [15:0] stall_pat = '0;
  int unsigned pat_cycles = 0;
  int unsigned hold_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (pat_cycles == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = '0;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'h8421 << $urandom_range(0, 3);
          default: stall_pat = 16'($urandom & $urandom);
        endcase
        pat_cycles = $urandom_range(20, 120);
      end else begin
        pat_cycles--;
      end
      out_stall <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // Monitor: predict on accepted bytes, check accepted results
  always @(posedge clk) begin
    bit hit;
    out_item_t rep;
    out_item_t want;
    byte_taken = 1'b0;
    if (!rst) begin
      stuck_cycles++;
      if (in_valid && !in_stall) begin
        byte_taken = 1'b1;
        stuck_cycles = 0;
        scan_byte(in_item, hit, rep);
        if (hit) awaited_reports = {awaited_reports, rep};
      end
      if (out_valid && !out_stall) begin
        stuck_cycles = 0;
        if (awaited_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got found=%0b offset=%0d",
                   $time, out_item.found, out_item.match_offset);
        end else begin
          want = awaited_reports.pop_front();
          if (out_item.found !== want.found) begin
            errors++;
            $display("%0t: found mismatch, expected %0b, got %0b",
                     $time, want.found, out_item.found);
          end
          if (out_item.match_offset !== want.match_offset) begin
            errors++;
            $display("%0t: match_offset mismatch, expected %0d, got %0d",
                     $time, want.match_offset, out_item.match_offset);
          end
        end
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_PATTERN_LOW: scan_cfg.pattern_low = value;
      CFG_PATTERN_HIGH: scan_cfg.pattern_high = value;
      CFG_NIBBLE_CARE: scan_cfg.nibble_care = value[31:0];
      CFG_PATTERN_LENGTH: scan_cfg.pattern_length = value[LEN_BITS-1:0];
      CFG_OCCURRENCE_INDEX: scan_cfg.occurrence_index = value[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] data, input bit last);
    in_item_t it;
    it.data_byte = data;
    it.last_byte = last;
    byte_q = {byte_q, it};
  endtask

  // Wait until every byte is in and every report is out, then let the
  // pipeline settle for bytes that produce no report.
  task automatic drain();
    while (byte_q.size() != 0 || in_valid || awaited_reports.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Signature byte k with wildcard nibbles filled at random
  function automatic logic [7:0] sig_instance(input int unsigned k);
    logic [7:0] b;
    logic [127:0] sig;
    sig = {scan_cfg.pattern_high, scan_cfg.pattern_low};
    b = 8'($urandom);
    if (scan_cfg.nibble_care[2*k]) b[3:0] = sig[8*k +: 4];
    if (scan_cfg.nibble_care[2*k+1]) b[7:4] = sig[8*k+4 +: 4];
    return b;
  endfunction

  // One region of random filler with copies of the signature; returns bytes queued
  task automatic queue_region(output int unsigned added);
    logic [7:0] region [$];
    int unsigned len;
    int unsigned span;
    int unsigned copies;
    int unsigned at;
    int unsigned cut;
    bit noise;
    len = active_length();
    noise = ($urandom_range(0, 7) == 0);
    span = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len)
                                       : $urandom_range(len, len + 24);
    for (int i = 0; i < span; i++) region = {region, 8'($urandom)};
    copies = noise ? 0 : $urandom_range(0, 3);
    for (int c = 0; c < copies; c++) begin
      if (span >= len) begin
        at = $urandom_range(0, span - len);
        // sometimes a broken copy that stops early or has one bad byte
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : len;
        for (int k = 0; k < cut; k++) region[at + k] = sig_instance(k);
        if ($urandom_range(0, 6) == 0) region[at + $urandom_range(0, len - 1)] ^= 8'h10;
      end
    end
    for (int i = 0; i < span; i++)
      queue_byte(region[i], (i == span - 1) && !(noise && $urandom_range(0, 1) == 1));
    added = span;
  endtask

  initial begin
    int unsigned added;
    int unsigned phase_bytes;
    logic [31:0] care;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: no match, match at offset 1, then a report-free last byte
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    drain();

    // Length zero acts as one; second match lands on the last byte
    write_reg(CFG_PATTERN_LOW, '1);
    write_reg(CFG_PATTERN_HIGH, '1);
    write_reg(CFG_PATTERN_LENGTH, 64'd0);
    write_reg(CFG_OCCURRENCE_INDEX, 64'd1);
    @(posedge clk);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    drain();

    // Zeroed window must not match before the region holds enough bytes
    write_reg(CFG_PATTERN_LOW, 64'd0);
    write_reg(CFG_PATTERN_LENGTH, 64'd2);
    write_reg(CFG_OCCURRENCE_INDEX, 64'd0);
    @(posedge clk);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b1);
    drain();

    // Largest length code clamps to sixteen, all nibbles wildcard
    write_reg(CFG_NIBBLE_CARE, 64'd0);
    write_reg(CFG_PATTERN_LENGTH, 64'd31);
    @(posedge clk);
    for (int i = 0; i < PATTERN_MAX; i++) queue_byte(8'($urandom), i == PATTERN_MAX - 1);
    drain();

    // Highest occurrence index: every byte matches, region ends short of it
    write_reg(CFG_PATTERN_LENGTH, 64'd1);
    write_reg(CFG_OCCURRENCE_INDEX, 64'hFFFF);
    @(posedge clk);
    for (int i = 0; i < 24; i++) queue_byte(8'($urandom), i == 23);
    drain();

    // Back-to-back short regions while the receiver holds off
    write_reg(CFG_OCCURRENCE_INDEX, 64'd0);
    @(posedge clk);
    steady_send = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) queue_byte(8'($urandom), $urandom_range(0, 1));
    queue_byte(8'($urandom), 1'b1);
    drain();
    steady_send = 1'b0;

    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 3))
        0: care = '1;
        1: care = $urandom;
        2: care = $urandom | $urandom;
        default: care = ($urandom_range(0, 2) == 0) ? 32'd0 : ($urandom | $urandom | $urandom);
      endcase
      write_reg(CFG_PATTERN_LOW, {$urandom, $urandom});
      write_reg(CFG_PATTERN_HIGH, {$urandom, $urandom});
      write_reg(CFG_NIBBLE_CARE, 64'(care));
      write_reg(CFG_PATTERN_LENGTH, ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 31))
                                                               : 64'($urandom_range(1, 16)));
      write_reg(CFG_OCCURRENCE_INDEX, ($urandom_range(0, 9) == 0)
                                      ? 64'($urandom_range(0, 65535))
                                      : 64'($urandom_range(0, 3)));
      @(posedge clk);
      phase_bytes = 0;
      while (phase_bytes < 48) begin
        queue_region(added);
        phase_bytes += added;
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
